>>> hdl/imq_pkg.sv
// Package of shared types, codes and defaults for the indexed minimum priority queue.
`default_nettype none
package imq_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned KeyWidthDef = 16;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned KeyW    = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 7;

  typedef enum logic [FuncW-1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_CHANGE = 2'd2,
    FN_QUERY  = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_PRESENT = 3'd3,
    ST_ABSENT  = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_DEC,
    S_DL1,
    S_DL2,
    S_DL3,
    S_UP_CHK,
    S_UP_PK,
    S_UP_CMP,
    S_DN_CHK,
    S_DN_C1,
    S_DN_C2,
    S_DN_C3,
    S_FIN,
    S_TOP,
    S_T1,
    S_T2
  } state_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [IdxW-1:0]  entry_index;
    logic [KeyW-1:0]  key_value;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdxW-1:0]    removed_index;
    logic [IdxW-1:0]    min_index;
    logic [KeyW-1:0]    min_key;
    logic [CountW-1:0]  entry_count;
    logic               index_present;
  } out_item_t;

endpackage
`default_nettype wire

>>> hdl/imq_stream_if.sv
// Valid/ready stream interface carrying one payload item.
`default_nettype none
interface imq_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/imq_ram.sv
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module imq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

>>> hdl/indexed_min_priority_queue.sv
// Top level of the indexed binary minimum heap priority queue.
// Usage: items arrive on in_i (func, entry_index, key_value) and each one
// yields exactly one result item on out_o, in order. Both channels use a
// valid/ready handshake; an item moves when valid and ready are both high.
// The block works on one item at a time. in_i is ready only while the
// sequencer is idle; the result sits in an output register, so the next
// item may be accepted while the previous result still waits to be taken.
// Steps: a query or a refused request goes from decode straight to the
// gather states that load the result. An insert climbs, each level a
// slot read, a key read and a compare, then writes the moving entry; a
// delete first takes the top and the last entry, then sinks, each level
// with slot reads, key reads and compares; a key change climbs and sinks.
// The pace is set by the single port of each memory: every heap level
// costs a slot read, a key read and a compare, one after the other.
// After reset the slot-of-index memory is cleared, one entry per cycle;
// no item is accepted during that pass.
// If the receiver stalls, a finished result waits in its register and the
// sequencer holds before loading the next one; nothing is lost.
`default_nettype none
module indexed_min_priority_queue #(
  parameter int unsigned CAPACITY  = imq_pkg::CapacityDef,
  parameter int unsigned KEY_WIDTH = imq_pkg::KeyWidthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  imq_stream_if.sink   in_i,
  imq_stream_if.source out_o
);

  // Index, slot and count widths follow from the capacity.
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned SW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = KEY_WIDTH;

  imq_pkg::state_e state_q, state_d;

  logic [SW-1:0]  cnt_q, cnt_d;
  logic [SW-1:0]  pos_q, pos_d;
  logic [IW-1:0]  cur_idx_q, cur_idx_d;
  logic [KW-1:0]  cur_key_q, cur_key_d;
  logic [IW-1:0]  c1_idx_q, c1_idx_d;
  logic [KW-1:0]  c1_key_q, c1_key_d;
  logic [IW-1:0]  par_q, par_d;
  logic [IW-1:0]  removed_q, removed_d;
  logic [IW-1:0]  top_idx_q, top_idx_d;
  logic           sink_q, sink_d;
  logic           present_q, present_d;
  imq_pkg::status_e status_q, status_d;
  logic [IW-1:0]  clr_q, clr_d;

  imq_pkg::func_e func_q, func_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic           inr_q, inr_d;
  logic [KW-1:0]  key_q, key_d;

  imq_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  // Memory ports.
  logic          hs_we, hs_re;
  logic [SW-1:0] hs_addr;
  logic [IW-1:0] hs_wdata, hs_rdata;
  logic          ks_we, ks_re;
  logic [IW-1:0] ks_addr;
  logic [KW-1:0] ks_wdata, ks_rdata;
  logic          so_we, so_re;
  logic [IW-1:0] so_addr;
  logic [SW-1:0] so_wdata, so_rdata;

  // Index held in each heap slot.
  imq_ram #(.WIDTH(IW), .DEPTH(CAPACITY + 1)) u_heap_slots (
    .clk_i  (clk_i),
    .we_i   (hs_we),
    .re_i   (hs_re),
    .addr_i (hs_addr),
    .wdata_i(hs_wdata),
    .rdata_o(hs_rdata)
  );

  // Key of each index.
  imq_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_store (
    .clk_i  (clk_i),
    .we_i   (ks_we),
    .re_i   (ks_re),
    .addr_i (ks_addr),
    .wdata_i(ks_wdata),
    .rdata_o(ks_rdata)
  );

  // Heap slot of each index; zero means the index is absent.
  imq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_slot_of_index (
    .clk_i  (clk_i),
    .we_i   (so_we),
    .re_i   (so_re),
    .addr_i (so_addr),
    .wdata_i(so_wdata),
    .rdata_o(so_rdata)
  );

  assign in_i.ready  = (state_q == imq_pkg::S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Child slot numbers are one bit wider than a slot, since 2*pos may exceed the capacity.
  logic [SW:0] child1;
  logic [SW:0] cnt_ext;
  assign child1  = {pos_q, 1'b0};
  assign cnt_ext = {1'b0, cnt_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    cur_idx_d   = cur_idx_q;
    cur_key_d   = cur_key_q;
    c1_idx_d    = c1_idx_q;
    c1_key_d    = c1_key_q;
    par_d       = par_q;
    removed_d   = removed_q;
    top_idx_d   = top_idx_q;
    sink_d      = sink_q;
    present_d   = present_q;
    status_d    = status_q;
    clr_d       = clr_q;
    func_d      = func_q;
    idx_d       = idx_q;
    inr_d       = inr_q;
    key_d       = key_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    hs_we = 1'b0; hs_re = 1'b0; hs_addr = '0; hs_wdata = '0;
    ks_we = 1'b0; ks_re = 1'b0; ks_addr = '0; ks_wdata = '0;
    so_we = 1'b0; so_re = 1'b0; so_addr = '0; so_wdata = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      imq_pkg::S_CLR: begin
        so_we   = 1'b1;
        so_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == IW'(CAPACITY - 1)) begin
          state_d = imq_pkg::S_IDLE;
        end
      end

      imq_pkg::S_IDLE: begin
        if (in_i.valid) begin
          func_d   = imq_pkg::func_e'(in_i.data.func);
          idx_d    = IW'(in_i.data.entry_index);
          inr_d    = 32'(in_i.data.entry_index) < 32'(CAPACITY);
          key_d    = KW'(in_i.data.key_value);
          removed_d = '0;
          status_d = imq_pkg::ST_OK;
          so_re    = 1'b1;
          so_addr  = IW'(in_i.data.entry_index);
          state_d  = imq_pkg::S_DEC;
        end
      end

      imq_pkg::S_DEC: begin
        state_d = imq_pkg::S_TOP;
        case (func_q)
          imq_pkg::FN_INSERT: begin
            if (cnt_q >= SW'(CAPACITY)) begin
              status_d = imq_pkg::ST_FULL;
            end else if (!inr_q) begin
              status_d = imq_pkg::ST_ABSENT;
            end else if (so_rdata != '0) begin
              status_d = imq_pkg::ST_PRESENT;
            end else begin
              cnt_d     = cnt_q + 1'b1;
              pos_d     = cnt_q + 1'b1;
              ks_we     = 1'b1;
              ks_addr   = idx_q;
              ks_wdata  = key_q;
              cur_idx_d = idx_q;
              cur_key_d = key_q;
              sink_d    = 1'b0;
              state_d   = imq_pkg::S_UP_CHK;
            end
          end
          imq_pkg::FN_DELETE: begin
            if (cnt_q == '0) begin
              status_d = imq_pkg::ST_EMPTY;
            end else begin
              hs_re   = 1'b1;
              hs_addr = SW'(1);
              state_d = imq_pkg::S_DL1;
            end
          end
          imq_pkg::FN_CHANGE: begin
            if (!inr_q || so_rdata == '0) begin
              status_d = imq_pkg::ST_ABSENT;
            end else begin
              ks_we     = 1'b1;
              ks_addr   = idx_q;
              ks_wdata  = key_q;
              cur_idx_d = idx_q;
              cur_key_d = key_q;
              pos_d     = so_rdata;
              sink_d    = 1'b1;
              state_d   = imq_pkg::S_UP_CHK;
            end
          end
          default: begin
            status_d = imq_pkg::ST_OK;
          end
        endcase
      end

      // Delete: take the top, pull the last entry up as the moving element.
      imq_pkg::S_DL1: begin
        removed_d = hs_rdata;
        so_we     = 1'b1;
        so_addr   = hs_rdata;
        hs_re     = 1'b1;
        hs_addr   = cnt_q;
        state_d   = imq_pkg::S_DL2;
      end

      imq_pkg::S_DL2: begin
        cur_idx_d = hs_rdata;
        ks_re     = 1'b1;
        ks_addr   = hs_rdata;
        cnt_d     = cnt_q - 1'b1;
        state_d   = imq_pkg::S_DL3;
      end

      imq_pkg::S_DL3: begin
        cur_key_d = ks_rdata;
        pos_d     = SW'(1);
        sink_d    = 1'b1;
        state_d   = (cnt_q == '0) ? imq_pkg::S_TOP : imq_pkg::S_DN_CHK;
      end

      // Swim: the moving element stays in registers while parents drop into the hole.
      imq_pkg::S_UP_CHK: begin
        if (pos_q == SW'(1)) begin
          state_d = sink_q ? imq_pkg::S_DN_CHK : imq_pkg::S_FIN;
        end else begin
          hs_re   = 1'b1;
          hs_addr = pos_q >> 1;
          state_d = imq_pkg::S_UP_PK;
        end
      end

      imq_pkg::S_UP_PK: begin
        par_d   = hs_rdata;
        ks_re   = 1'b1;
        ks_addr = hs_rdata;
        state_d = imq_pkg::S_UP_CMP;
      end

      imq_pkg::S_UP_CMP: begin
        if (ks_rdata > cur_key_q) begin
          hs_we    = 1'b1;
          hs_addr  = pos_q;
          hs_wdata = par_q;
          so_we    = 1'b1;
          so_addr  = par_q;
          so_wdata = pos_q;
          pos_d    = pos_q >> 1;
          state_d  = imq_pkg::S_UP_CHK;
        end else begin
          state_d = sink_q ? imq_pkg::S_DN_CHK : imq_pkg::S_FIN;
        end
      end

      // Sink: pick the smaller child, the left one on a tie.
      imq_pkg::S_DN_CHK: begin
        if (child1 > cnt_ext) begin
          state_d = imq_pkg::S_FIN;
        end else begin
          hs_re   = 1'b1;
          hs_addr = SW'(child1);
          state_d = imq_pkg::S_DN_C1;
        end
      end

      imq_pkg::S_DN_C1: begin
        c1_idx_d = hs_rdata;
        ks_re    = 1'b1;
        ks_addr  = hs_rdata;
        if (child1 < cnt_ext) begin
          hs_re   = 1'b1;
          hs_addr = SW'(child1 + 1'b1);
        end
        state_d = imq_pkg::S_DN_C2;
      end

      imq_pkg::S_DN_C2: begin
        c1_key_d = ks_rdata;
        if (child1 < cnt_ext) begin
          par_d   = hs_rdata;
          ks_re   = 1'b1;
          ks_addr = hs_rdata;
          state_d = imq_pkg::S_DN_C3;
        end else if (cur_key_q > ks_rdata) begin
          hs_we    = 1'b1;
          hs_addr  = pos_q;
          hs_wdata = c1_idx_q;
          so_we    = 1'b1;
          so_addr  = c1_idx_q;
          so_wdata = pos_q;
          pos_d    = SW'(child1);
          state_d  = imq_pkg::S_DN_CHK;
        end else begin
          state_d = imq_pkg::S_FIN;
        end
      end

      imq_pkg::S_DN_C3: begin
        if (c1_key_q > ks_rdata) begin
          if (cur_key_q > ks_rdata) begin
            hs_we    = 1'b1;
            hs_addr  = pos_q;
            hs_wdata = par_q;
            so_we    = 1'b1;
            so_addr  = par_q;
            so_wdata = pos_q;
            pos_d    = SW'(child1 + 1'b1);
            state_d  = imq_pkg::S_DN_CHK;
          end else begin
            state_d = imq_pkg::S_FIN;
          end
        end else if (cur_key_q > c1_key_q) begin
          hs_we    = 1'b1;
          hs_addr  = pos_q;
          hs_wdata = c1_idx_q;
          so_we    = 1'b1;
          so_addr  = c1_idx_q;
          so_wdata = pos_q;
          pos_d    = SW'(child1);
          state_d  = imq_pkg::S_DN_CHK;
        end else begin
          state_d = imq_pkg::S_FIN;
        end
      end

      imq_pkg::S_FIN: begin
        hs_we    = 1'b1;
        hs_addr  = pos_q;
        hs_wdata = cur_idx_q;
        so_we    = 1'b1;
        so_addr  = cur_idx_q;
        so_wdata = pos_q;
        state_d  = imq_pkg::S_TOP;
      end

      // Gather the top entry and the presence of the requested index.
      imq_pkg::S_TOP: begin
        hs_re   = 1'b1;
        hs_addr = SW'(1);
        so_re   = 1'b1;
        so_addr = idx_q;
        state_d = imq_pkg::S_T1;
      end

      imq_pkg::S_T1: begin
        top_idx_d = hs_rdata;
        present_d = inr_q && (so_rdata != '0);
        ks_re     = 1'b1;
        ks_addr   = hs_rdata;
        state_d   = imq_pkg::S_T2;
      end

      imq_pkg::S_T2: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.status        = status_q;
          out_d.removed_index = imq_pkg::IdxW'(removed_q);
          out_d.min_index     = (cnt_q == '0) ? '0 : imq_pkg::IdxW'(top_idx_q);
          out_d.min_key       = (cnt_q == '0) ? '0 : imq_pkg::KeyW'(ks_rdata);
          out_d.entry_count   = imq_pkg::CountW'(cnt_q);
          out_d.index_present = present_q;
          out_valid_d         = 1'b1;
          state_d             = imq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = imq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imq_pkg::S_CLR;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    cur_idx_q <= cur_idx_d;
    cur_key_q <= cur_key_d;
    c1_idx_q  <= c1_idx_d;
    c1_key_q  <= c1_key_d;
    par_q     <= par_d;
    removed_q <= removed_d;
    top_idx_q <= top_idx_d;
    sink_q    <= sink_d;
    present_q <= present_d;
    status_q  <= status_d;
    func_q    <= func_d;
    idx_q     <= idx_d;
    inr_q     <= inr_d;
    key_q     <= key_d;
    out_q     <= out_d;
  end

  // The entry count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SW'(CAPACITY))
    else $error("entry count above capacity");

  // A new result is only loaded from the final gather state.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == imq_pkg::S_T2))
    else $error("result loaded outside gather state");

  // A refused delete reports an empty heap.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == imq_pkg::ST_EMPTY) |-> (out_q.entry_count == '0))
    else $error("empty status with entries present");

  // A refused insert on a full heap reports a full count.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == imq_pkg::ST_FULL)
      |-> (out_q.entry_count == imq_pkg::CountW'(CAPACITY)))
    else $error("full status with heap not full");

endmodule
`default_nettype wire

>>> tb/imq_heap_checker.sv
// Checker for the indexed minimum priority queue: predicts each result and compares it.
`timescale 1ns / 100ps
module imq_heap_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_ready_i,
  input  imq_pkg::in_item_t  in_data_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_ready_i,
  input  imq_pkg::out_item_t out_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 result_count_o
);

  localparam int unsigned Cap = imq_pkg::CapacityDef;

  logic [imq_pkg::IdxW-1:0]   heap_idx [1:Cap];
  logic [imq_pkg::CountW-1:0] slot_of [0:Cap-1];
  logic [imq_pkg::KeyW-1:0]   key_of [0:Cap-1];
  int unsigned heap_size;
  imq_pkg::out_item_t awaited_q[$];

  // True when the key in slot a is strictly greater than the key in slot b.
  function automatic bit slot_above(int unsigned a, int unsigned b);
    return key_of[heap_idx[a]] > key_of[heap_idx[b]];
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [imq_pkg::IdxW-1:0] t;
    t = heap_idx[a];
    heap_idx[a] = heap_idx[b];
    heap_idx[b] = t;
    slot_of[heap_idx[a]] = imq_pkg::CountW'(a);
    slot_of[heap_idx[b]] = imq_pkg::CountW'(b);
  endfunction

  function automatic void climb(int unsigned s);
    while (s > 1 && slot_above(s / 2, s)) begin
      swap_slots(s / 2, s);
      s = s / 2;
    end
  endfunction

  function automatic void sink(int unsigned s);
    int unsigned c;
    while (2 * s <= heap_size) begin
      c = 2 * s;
      if (c < heap_size && slot_above(c, c + 1)) c++;
      if (!slot_above(s, c)) break;
      swap_slots(s, c);
      s = c;
    end
  endfunction

  // Applies one request to the shadow heap and returns the result it should give.
  function automatic imq_pkg::out_item_t heap_apply(imq_pkg::in_item_t it);
    imq_pkg::out_item_t r;
    int unsigned i;
    i = int'(it.entry_index);
    r = '0;
    r.status = imq_pkg::ST_OK;
    case (imq_pkg::func_e'(it.func))
      imq_pkg::FN_INSERT: begin
        if (heap_size >= Cap) r.status = imq_pkg::ST_FULL;
        else if (slot_of[i] != 0) r.status = imq_pkg::ST_PRESENT;
        else begin
          heap_size++;
          slot_of[i] = imq_pkg::CountW'(heap_size);
          heap_idx[heap_size] = imq_pkg::IdxW'(i);
          key_of[i] = it.key_value;
          climb(heap_size);
        end
      end
      imq_pkg::FN_DELETE: begin
        if (heap_size == 0) r.status = imq_pkg::ST_EMPTY;
        else begin
          r.removed_index = heap_idx[1];
          heap_idx[1] = heap_idx[heap_size];
          slot_of[heap_idx[1]] = imq_pkg::CountW'(1);
          slot_of[r.removed_index] = '0;
          heap_size--;
          sink(1);
        end
      end
      imq_pkg::FN_CHANGE: begin
        if (slot_of[i] == 0) r.status = imq_pkg::ST_ABSENT;
        else begin
          key_of[i] = it.key_value;
          climb(slot_of[i]);
          sink(slot_of[i]);
        end
      end
      default: ;
    endcase
    if (heap_size > 0) begin
      r.min_index = heap_idx[1];
      r.min_key = key_of[heap_idx[1]];
    end
    r.entry_count = imq_pkg::CountW'(heap_size);
    r.index_present = (slot_of[i] != 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    imq_pkg::out_item_t e;
    if (!rst_ni) begin
      heap_size = 0;
      for (int k = 0; k < Cap; k++) slot_of[k] = '0;
      awaited_q.delete();
      fail_count_o <= 0;
      result_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) awaited_q.push_back(heap_apply(in_data_i));
      if (out_valid_i && out_ready_i) begin
        result_count_o <= result_count_o + 1;
        if (awaited_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result %p", out_data_i);
        end else begin
          e = awaited_q.pop_front();
          if (e !== out_data_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: expected %p got %p", e, out_data_i);
          end
        end
      end
      pending_o <= awaited_q.size();
    end
  end

endmodule

>>> tb/indexed_min_priority_queue_tb.sv
// Testbench top: drives requests into the priority queue and gives the verdict.
`timescale 1ns / 100ps
module indexed_min_priority_queue_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  imq_stream_if #(.T(imq_pkg::in_item_t))  req_if ();
  imq_stream_if #(.T(imq_pkg::out_item_t)) rsp_if ();

  indexed_min_priority_queue uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (rsp_if.source)
  );

  int fail_count, pending, result_count;

  imq_heap_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_if.valid),
    .in_ready_i    (req_if.ready),
    .in_data_i     (req_if.data),
    .out_valid_i   (rsp_if.valid),
    .out_ready_i   (rsp_if.ready),
    .out_data_i    (rsp_if.data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .result_count_o(result_count)
  );

  // The cycle counter ends the run if the block hangs.
  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** indexed_min_priority_queue: FAILED **");
      $finish;
    end
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // The receiver stalls at random, and once holds off for a long stretch
  // while the sender carries on, so that the input side must back up.
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  initial begin
    int unsigned n;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        rsp_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold_done = 1'b1;
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      n = gap_len();
      if (n > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  int unsigned sent = 0;
  int unsigned n_ins = 0, n_del = 0, n_chg = 0, n_qry = 0;
  bit sequences_mode = 1'b0;

  // Offers one item and holds it until it is taken.
  task automatic send(imq_pkg::func_e f, logic [imq_pkg::IdxW-1:0] idx,
                      logic [imq_pkg::KeyW-1:0] key);
    imq_pkg::in_item_t it;
    int unsigned g;
    it.func = f;
    it.entry_index = idx;
    it.key_value = key;
    req_if.valid <= 1'b1;
    req_if.data <= it;
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
    case (f)
      imq_pkg::FN_INSERT: n_ins++;
      imq_pkg::FN_DELETE: n_del++;
      imq_pkg::FN_CHANGE: n_chg++;
      default:            n_qry++;
    endcase
    g = (sequences_mode) ? gap_len() : 0;
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned p, phase_kind;
    req_if.valid = 1'b0;
    req_if.data = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty cases, key extremes, equal keys and refusals.
    send(imq_pkg::FN_DELETE, 6'd0, 16'h0000);
    send(imq_pkg::FN_QUERY, 6'd63, 16'hFFFF);
    send(imq_pkg::FN_CHANGE, 6'd5, 16'h1234);
    send(imq_pkg::FN_INSERT, 6'd63, 16'hFFFF);
    send(imq_pkg::FN_INSERT, 6'd0, 16'h0000);
    send(imq_pkg::FN_INSERT, 6'd0, 16'h5555);
    send(imq_pkg::FN_INSERT, 6'd21, 16'hAAAA);
    send(imq_pkg::FN_INSERT, 6'd42, 16'hAAAA);
    send(imq_pkg::FN_CHANGE, 6'd0, 16'hFFFF);
    send(imq_pkg::FN_CHANGE, 6'd63, 16'h0000);
    send(imq_pkg::FN_QUERY, 6'd42, 16'h0);
    repeat (5) send(imq_pkg::FN_DELETE, 6'd0, 16'h0);
    // Fill to capacity, then push once more to get the full refusal.
    sequences_mode = 1'b1;
    for (int k = 0; k < 64; k++) send(imq_pkg::FN_INSERT, k[5:0], 16'($urandom));
    send(imq_pkg::FN_INSERT, 6'd7, 16'h0001);
    send(imq_pkg::FN_QUERY, 6'd7, 16'h0);
    // The long hold-off while the sender keeps offering items.
    long_hold_req = 1'b1;
    for (int k = 0; k < 20; k++) send(imq_pkg::FN_CHANGE, 6'($urandom), 16'($urandom));
    repeat (70) send(imq_pkg::FN_DELETE, 6'd0, 16'h0);

    // Random part: phases biased towards filling, draining or churning, with
    // narrow key ranges at times so that equal keys are common.
    while (sent < 1900) begin
      phase_kind = $urandom_range(2);
      for (int k = 0; k < 100; k++) begin
        p = $urandom_range(99);
        if (phase_kind == 0 && p < 60 || phase_kind != 0 && p < 30)
          send(imq_pkg::FN_INSERT, 6'($urandom),
               (phase_kind == 2) ? 16'($urandom_range(3)) : 16'($urandom));
        else if (phase_kind == 1 && p < 80 || p < 55)
          send(imq_pkg::FN_DELETE, 6'($urandom), 16'($urandom));
        else if (p < 90)
          send(imq_pkg::FN_CHANGE, 6'($urandom),
               (phase_kind == 2) ? 16'($urandom_range(3)) : 16'($urandom));
        else send(imq_pkg::FN_QUERY, 6'($urandom), 16'($urandom));
      end
    end
    req_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Ran %0d requests: %0d inserts, %0d deletes, %0d key changes, %0d queries;",
             sent, n_ins, n_del, n_chg, n_qry);
    $display("%0d results checked, %0d mismatches.", result_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** indexed_min_priority_queue: PASSED **");
    end else begin
      $display("** indexed_min_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/imq_pkg.sv
hdl/imq_stream_if.sv
hdl/imq_ram.sv
hdl/indexed_min_priority_queue.sv
tb/imq_heap_checker.sv
tb/indexed_min_priority_queue_tb.sv
